### hw/rtl/reentrant_reader_writer_lock_defines.svh
// ----------------------------------------------------------------------------
// reentrant_reader_writer_lock_defines
// Assertion macros for the reader-writer lock manager.
// ----------------------------------------------------------------------------
`ifndef REENTRANT_READER_WRITER_LOCK_DEFINES_SVH
`define REENTRANT_READER_WRITER_LOCK_DEFINES_SVH
// property that must hold on every clock edge out of reset
`define RRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define RRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/rrwl_pkg.sv
// ----------------------------------------------------------------------------
// rrwl_pkg
// Types and constants shared by the reader-writer lock manager.
// ----------------------------------------------------------------------------
package rrwl_pkg;
  localparam int unsigned Threads   = 16;
  localparam int unsigned TidW      = 4;
  localparam int unsigned NestBits  = 8;
  localparam int unsigned TotalBits = 12;
  localparam logic [NestBits-1:0]  NestMax  = '1;
  localparam logic [TotalBits-1:0] TotalMax = '1;

  localparam logic [1:0] CmdRead   = 2'd0;
  localparam logic [1:0] CmdWrite  = 2'd1;
  localparam logic [1:0] CmdUnlock = 2'd2;
  localparam logic [1:0] CmdStatus = 2'd3;

  localparam logic [3:0] OutGranted   = 4'd0;
  localparam logic [3:0] OutWaiting   = 4'd1;
  localparam logic [3:0] OutWrRead    = 4'd2;
  localparam logic [3:0] OutRdUnlNh   = 4'd3;
  localparam logic [3:0] OutWrUnlNh   = 4'd4;
  localparam logic [3:0] OutUnlFree   = 4'd5;
  localparam logic [3:0] OutParked    = 4'd6;
  localparam logic [3:0] OutOverflow  = 4'd7;
  localparam logic [3:0] OutStatus    = 4'd8;

  localparam logic [1:0] HoldNone  = 2'd0;
  localparam logic [1:0] HoldRead  = 2'd1;
  localparam logic [1:0] HoldWrite = 2'd2;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [TidW-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [TidW-1:0] subject_thread;
    logic [3:0]      outcome;
    logic [1:0]      lock_state;
    logic [1:0]      own_state;
    logic            last;
  } rsp_t;
endpackage

### hw/rtl/rrwl_ram.sv
// ----------------------------------------------------------------------------
// rrwl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rrwl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/reentrant_reader_writer_lock.sv
// A request is captured into req_q; its result word is made in StRead and
// registered with strobe. No request is taken until its last word is out
// (busy). Waking n readers adds n grant words (one per cycle), a writer one.
// Results cannot be stalled: each word is shown for exactly one cycle.
// Reset: asynchronous; all nesting counts read as zero through per-thread
// valid bits, so no clearing pass is needed and requests are taken at once.
module reentrant_reader_writer_lock
  import rrwl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic strobe,
  output rsp_t rsp_o
);
`include "reentrant_reader_writer_lock_defines.svh"

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StWake = 4'b0100,
    StLast = 4'b1000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic [Threads-1:0]   valid_q, valid_d;
  logic [TotalBits-1:0] total_q, total_d;
  logic [NestBits-1:0]  wnest_q, wnest_d;
  logic [TidW-1:0]      wown_q, wown_d;
  logic [Threads-1:0]   wrd_q, wrd_d, wwr_q, wwr_d;
  logic [Threads-1:0]   wake_q, wake_d;
  logic                 strobe_d, strobe_q;
  rsp_t                 rsp_d, rsp_q;

  logic                ram_we;
  logic [TidW-1:0]     ram_wa, ram_ra;
  logic [NestBits-1:0] ram_wd, ram_rd;

  rrwl_ram #(.Width(NestBits), .Depth(Threads)) u_nest_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  assign ram_ra = req_i.thread_id;
  assign busy   = (state_q != StIdle);
  assign strobe = strobe_q;
  assign rsp_o  = rsp_q;

  logic [NestBits-1:0] rn;
  logic [TidW-1:0]     t;
  logic [TidW-1:0]     low_w, low_r;
  logic [3:0]          oc;
  logic                wake;
  logic                in_range;

  assign t        = req_q.thread_id;
  assign in_range = ({1'b0, t} < 5'(Threads));
  assign rn       = valid_q[t] ? ram_rd : '0;

  // lowest set bit of the waiting masks
  always_comb begin
    low_w = '0;
    low_r = '0;
    for (int i = Threads - 1; i >= 0; i--) begin
      if (wwr_q[i]) low_w = TidW'(i);
      if (wake_q[i]) low_r = TidW'(i);
    end
  end

  function automatic logic [1:0] gstate(logic [NestBits-1:0] wn, logic [TotalBits-1:0] tr);
    if (wn != '0) return HoldWrite;
    if (tr != '0) return HoldRead;
    return HoldNone;
  endfunction

  always_comb begin
    logic [NestBits-1:0] rn_new;
    logic                reent;
    logic [1:0]          own;
    state_d  = state_q;
    valid_d  = valid_q;
    total_d  = total_q;
    wnest_d  = wnest_q;
    wown_d   = wown_q;
    wrd_d    = wrd_q;
    wwr_d    = wwr_q;
    wake_d   = wake_q;
    strobe_d = 1'b0;
    rsp_d    = rsp_q;
    ram_we   = 1'b0;
    ram_wa   = t;
    ram_wd   = '0;
    rn_new   = rn;
    oc       = OutStatus;
    wake     = 1'b0;
    reent    = 1'b0;
    own      = HoldNone;
    unique case (state_q)
      StIdle: begin
        if (start) state_d = StRead;
      end
      StRead: begin
        if (in_range && req_q.cmd != CmdStatus) begin
          if (wrd_q[t] || wwr_q[t]) begin
            oc = OutParked;
          end else begin
            case (req_q.cmd)
              CmdRead: begin
                reent = (wnest_q != '0 && wown_q == t) || rn != '0;
                if (!reent && (wnest_q != '0 || wwr_q != '0)) begin
                  wrd_d[t] = 1'b1;
                  oc = OutWaiting;
                end else if (rn == NestMax || total_q == TotalMax) begin
                  oc = OutOverflow;
                end else begin
                  rn_new  = rn + 1'b1;
                  total_d = total_q + 1'b1;
                  oc = OutGranted;
                end
              end
              CmdWrite: begin
                if (total_q != '0 && rn != '0) begin
                  oc = OutWrRead;
                end else if (total_q != '0 || (wnest_q != '0 && wown_q != t)) begin
                  wwr_d[t] = 1'b1;
                  oc = OutWaiting;
                end else if (wnest_q == NestMax) begin
                  oc = OutOverflow;
                end else begin
                  wown_d  = t;
                  wnest_d = wnest_q + 1'b1;
                  oc = OutGranted;
                end
              end
              default: begin
                if (total_q != '0) begin
                  if (rn == '0) begin
                    oc = OutRdUnlNh;
                  end else begin
                    rn_new  = rn - 1'b1;
                    total_d = total_q - 1'b1;
                    oc = OutGranted;
                  end
                end else if (wnest_q != '0) begin
                  if (wown_q != t) begin
                    oc = OutWrUnlNh;
                  end else begin
                    wnest_d = wnest_q - 1'b1;
                    oc = OutGranted;
                  end
                end else begin
                  oc = OutUnlFree;
                end
                wake = (oc == OutGranted) && total_d == '0 && wnest_d == '0
                       && (wwr_q != '0 || wrd_q != '0);
              end
            endcase
          end
        end
        if (oc == OutGranted && req_q.cmd != CmdWrite) begin
          ram_we     = 1'b1;
          ram_wd     = rn_new;
          valid_d[t] = 1'b1;
        end
        // writer wake is folded into the state update here
        if (wake && wwr_q != '0) begin
          wwr_d[low_w] = 1'b0;
          wown_d  = low_w;
          wnest_d = NestBits'(1);
        end
        if (!in_range) own = HoldNone;
        else if (wnest_d != '0 && wown_d == t) own = HoldWrite;
        else if (total_d != '0 && rn_new != '0) own = HoldRead;
        strobe_d = 1'b1;
        rsp_d.subject_thread = t;
        rsp_d.outcome        = oc;
        rsp_d.lock_state     = (wake && wwr_q == '0) ? HoldNone : gstate(wnest_d, total_d);
        rsp_d.own_state      = own;
        rsp_d.last           = !wake;
        if (wake && wwr_q != '0) begin
          rsp_d.lock_state = HoldWrite;
          wake_d  = '0;
          state_d = StLast;
        end else if (wake) begin
          // readers are granted all at once; lock state of every word is read
          wake_d  = wrd_q;
          wrd_d   = '0;
          total_d = total_d + TotalBits'($countones(wrd_q));
          rsp_d.lock_state = HoldRead;
          state_d = StWake;
        end else begin
          state_d = StIdle;
        end
      end
      StLast: begin
        strobe_d = 1'b1;
        rsp_d.subject_thread = wown_q;
        rsp_d.outcome        = OutGranted;
        rsp_d.lock_state     = HoldWrite;
        rsp_d.own_state      = HoldWrite;
        rsp_d.last           = 1'b1;
        state_d = StIdle;
      end
      StWake: begin
        ram_we          = 1'b1;
        ram_wa          = low_r;
        ram_wd          = NestBits'(1);
        valid_d[low_r]  = 1'b1;
        wake_d[low_r]   = 1'b0;
        strobe_d = 1'b1;
        rsp_d.subject_thread = low_r;
        rsp_d.outcome        = OutGranted;
        rsp_d.lock_state     = HoldRead;
        rsp_d.own_state      = HoldRead;
        rsp_d.last           = (wake_d == '0);
        if (wake_d == '0) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= '0;
      total_q  <= '0;
      wnest_q  <= '0;
      wown_q   <= '0;
      wrd_q    <= '0;
      wwr_q    <= '0;
      wake_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      total_q  <= total_d;
      wnest_q  <= wnest_d;
      wown_q   <= wown_d;
      wrd_q    <= wrd_d;
      wwr_q    <= wwr_d;
      wake_q   <= wake_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (start && !busy) req_q <= req_i;
  end

  `RRW_ASSERT(a_onehot, $onehot(state_q), "state not one-hot")
  `RRW_ASSERT(a_wait_disjoint, (wrd_q & wwr_q) == '0, "thread parked twice")
  `RRW_ASSERT(a_wake_only, state_q == StWake || wake_q == '0, "stray reader wake")
  `RRW_ASSERT_NEXT(a_read_strobe, state_q == StRead, strobe, "missing requester word")
  `RRW_ASSERT_NEXT(a_wake_nonzero, state_q == StWake && wake_q != '0, strobe, "missing grant word")
endmodule
